// ===== rtl/tga_pkg.sv =====
// shared types, constants and arithmetic helpers of the twiddle gain autotuner
`default_nettype none

package tga_pkg;

  localparam int unsigned NUM_GAINS_DEF = 3;
  localparam int unsigned INIT_GAINS    = 3;
  localparam int unsigned GAIN_W        = 32;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned SQ_W          = 31;
  localparam int unsigned ERR_W         = 48;
  localparam int unsigned RUN_W         = 16;
  localparam int unsigned TOL_W         = 31;

  localparam logic [ERR_W-1:0] ERR_MAX     = '1;
  localparam logic [31:0]      TENTH_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned      TENTH_SHIFT = 35;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_KP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_KI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_KD = 3'd4;

  localparam logic [RUN_W-1:0] RUN_LENGTH_RST = 16'd4500;
  localparam logic [TOL_W-1:0] TOLERANCE_RST  = 31'd75497;

  typedef enum logic [1:0] {
    PH_TRY_PLUS  = 2'd0,
    PH_TRY_MINUS = 2'd1,
    PH_SETTLE    = 2'd2
  } phase_t;

  // a value divided by ten: rounded half away from zero, plus a flag for an exact half
  typedef struct packed {
    logic signed [GAIN_W-1:0] up;
    logic                     tie;
  } tenth_t;

  function automatic logic signed [GAIN_W-1:0] sat32(input logic signed [GAIN_W+1:0] v);
    logic signed [GAIN_W+1:0] hi;
    logic signed [GAIN_W+1:0] lo;
    hi = (GAIN_W+2)'(32'sh7FFF_FFFF);
    lo = -(GAIN_W+2)'(33'sh0_8000_0000);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[GAIN_W-1:0];
  endfunction

  function automatic tenth_t tenth(input logic signed [GAIN_W-1:0] x);
    logic [31:0] mag;
    logic [31:0] n;
    logic [63:0] prod;
    logic [31:0] q;
    logic [31:0] q10;
    tenth_t      res;
    mag  = x[GAIN_W-1] ? (~x + 32'd1) : x;
    n    = mag + 32'd5;
    // floor(n / 10) by reciprocal multiply, exact for any 32-bit n
    prod = 64'(n) * 64'(TENTH_RECIP);
    q    = {3'b000, prod[63:TENTH_SHIFT]};
    q10  = (q << 3) + (q << 1);
    res.tie = (q10 == n);
    res.up  = x[GAIN_W-1] ? -$signed(q) : $signed(q);
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/twiddle_gain_autotuner_unit.sv =====
// twiddle coordinate-descent tuner for a set of pid gains, top level
//
// Takes signed Q6.10 error words and returns one result word per input word,
// via the input register and then the state update into the result register.
// Sustained rate is one word per clock while out_stall is low. A run ends when
// the sample count would exceed run_length; that word carries run_reset and,
// unless tuning is done or ends there (delta sum at most the tolerance),
// triggers one twiddle step on the gain pointed to by the internal gain index.
// Gains and deltas are signed Q8.24, error sums unsigned Q28.20 saturating at
// all ones. A delta is scaled by 1.1 / 0.9 via a per-gain tenth register
// refreshed every cycle from the delta. The restart delta (0.1 times the
// largest initial gain) is rebuilt from the configuration registers on the
// cycle after they are written; registers are to be written only while no
// word is in flight, which the block itself does not enforce.
`default_nettype none

module twiddle_gain_autotuner_unit #(
  parameter int unsigned NUM_GAINS = tga_pkg::NUM_GAINS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [tga_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [tga_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [tga_pkg::SAMPLE_W-1:0]   in_error_sample,
  input  wire logic                                  in_restart,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [tga_pkg::GAIN_W-1:0]          out_gain_p,
  output logic signed [tga_pkg::GAIN_W-1:0]          out_gain_i,
  output logic signed [tga_pkg::GAIN_W-1:0]          out_gain_d,
  output logic                                       out_run_reset,
  output logic                                       out_tuning_done
);
  import tga_pkg::*;

  localparam int unsigned IDX_W = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;
  localparam int unsigned SUM_W = GAIN_W + IDX_W;

  // configuration registers
  logic [RUN_W-1:0]         run_length_r;
  logic [TOL_W-1:0]         tolerance_r;
  logic signed [GAIN_W-1:0] init_gain_r [INIT_GAINS];
  logic signed [GAIN_W-1:0] restart_delta_r;
  logic signed [GAIN_W-1:0] restart_delta_nxt;
  logic signed [GAIN_W-1:0] restart_gain [NUM_GAINS];

  // input register
  logic            a_vld_r;
  logic [SQ_W-1:0] a_sq_r;
  logic            a_restart_r;
  logic [15:0]     in_mag;
  logic [31:0]     in_sq;

  // tuner state
  logic [RUN_W-1:0]         cnt_r,  cnt_nxt;
  logic [ERR_W-1:0]         sum_r,  sum_nxt;
  logic [ERR_W-1:0]         best_r, best_nxt;
  logic signed [GAIN_W-1:0] gain_r  [NUM_GAINS];
  logic signed [GAIN_W-1:0] gain_nxt[NUM_GAINS];
  logic signed [GAIN_W-1:0] delta_r [NUM_GAINS];
  logic signed [GAIN_W-1:0] delta_nxt[NUM_GAINS];
  tenth_t                   tenth_r [NUM_GAINS];
  logic [IDX_W-1:0]         idx_r,  idx_nxt;
  phase_t                   ph_r,   ph_nxt;
  logic                     fin_r,  fin_nxt;

  // values seen by the word in the input register, restart applied first
  logic signed [GAIN_W-1:0] g_eff[NUM_GAINS];
  logic signed [GAIN_W-1:0] d_eff[NUM_GAINS];
  logic [ERR_W-1:0]         best_eff;
  logic [ERR_W-1:0]         sum_eff;
  logic [RUN_W-1:0]         cnt_eff;
  logic [IDX_W-1:0]         idx_eff;
  phase_t                   ph_eff;
  logic                     fin_eff;

  logic [ERR_W:0]           sum_add;
  logic [ERR_W-1:0]         sum_new;
  logic [RUN_W:0]           cnt_inc;
  logic                     run_end;
  logic                     better;
  logic signed [SUM_W-1:0]  delta_total;
  logic signed [SUM_W-1:0]  tol_ext;
  logic [IDX_W-1:0]         j;
  logic [IDX_W:0]           j_inc;
  logic [IDX_W-1:0]         j_adv;
  logic signed [GAIN_W-1:0] gj, dj;
  tenth_t                   tj;
  logic signed [GAIN_W-1:0] t_dn;
  logic signed [GAIN_W-1:0] d_up11, d_dn9, g_plus, g_minus2;

  // handshake
  logic fire_ab;
  logic b_ready;
  logic o_vld_r;
  logic signed [GAIN_W-1:0] o_gain_r [INIT_GAINS];
  logic signed [GAIN_W-1:0] res_gain [INIT_GAINS];
  logic o_run_reset_r;
  logic o_done_r;

  assign b_ready  = !o_vld_r || !out_stall;
  assign fire_ab  = a_vld_r && b_ready;
  assign in_stall = a_vld_r && !b_ready;

  assign out_valid       = o_vld_r;
  assign out_gain_p      = o_gain_r[0];
  assign out_gain_i      = o_gain_r[1];
  assign out_gain_d      = o_gain_r[2];
  assign out_run_reset   = o_run_reset_r;
  assign out_tuning_done = o_done_r;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_length_r <= RUN_LENGTH_RST;
      tolerance_r  <= TOLERANCE_RST;
      for (int i = 0; i < INIT_GAINS; i++) begin
        init_gain_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RUN_LENGTH: run_length_r   <= cfg_wr_data[RUN_W-1:0];
        REG_TOLERANCE:  tolerance_r    <= cfg_wr_data[TOL_W-1:0];
        REG_INITIAL_KP: init_gain_r[0] <= $signed(cfg_wr_data);
        REG_INITIAL_KI: init_gain_r[1] <= $signed(cfg_wr_data);
        REG_INITIAL_KD: init_gain_r[2] <= $signed(cfg_wr_data);
        default: ;
      endcase
    end
  end

  // restart gains and the common restart delta (0.1 times the largest gain)
  always_comb begin
    logic signed [GAIN_W-1:0] top;
    tenth_t                   top_tenth;
    for (int i = 0; i < NUM_GAINS; i++) begin
      restart_gain[i] = (i < INIT_GAINS) ? init_gain_r[2'(i)] : '0;
    end
    top = restart_gain[0];
    for (int i = 1; i < NUM_GAINS; i++) begin
      if (restart_gain[i] > top) begin
        top = restart_gain[i];
      end
    end
    top_tenth         = tenth(top);
    restart_delta_nxt = top_tenth.up;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_delta_r <= '0;
    end else begin
      restart_delta_r <= restart_delta_nxt;
    end
  end

  // ---------------- input register ----------------
  assign in_mag = in_error_sample[SAMPLE_W-1] ? (~in_error_sample + 16'd1) : in_error_sample;
  assign in_sq  = in_mag * in_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (!in_stall) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_sq_r      <= in_sq[SQ_W-1:0];
      a_restart_r <= in_restart;
    end
  end

  // ---------------- state update ----------------
  always_comb begin
    for (int i = 0; i < NUM_GAINS; i++) begin
      g_eff[i] = a_restart_r ? restart_gain[i] : gain_r[i];
      d_eff[i] = a_restart_r ? restart_delta_r : delta_r[i];
    end
    best_eff = a_restart_r ? ERR_MAX     : best_r;
    sum_eff  = a_restart_r ? '0          : sum_r;
    cnt_eff  = a_restart_r ? '0          : cnt_r;
    idx_eff  = a_restart_r ? '0          : idx_r;
    ph_eff   = a_restart_r ? PH_TRY_PLUS : ph_r;
    fin_eff  = a_restart_r ? 1'b0        : fin_r;

    sum_add = {1'b0, sum_eff} + (ERR_W+1)'(a_sq_r);
    sum_new = sum_add[ERR_W] ? ERR_MAX : sum_add[ERR_W-1:0];
    cnt_inc = {1'b0, cnt_eff} + (RUN_W+1)'(1);
    run_end = cnt_inc > {1'b0, run_length_r};
    better  = sum_new < best_eff;

    delta_total = '0;
    for (int i = 0; i < NUM_GAINS; i++) begin
      delta_total = delta_total + SUM_W'(d_eff[i]);
    end
    tol_ext = $signed(SUM_W'(tolerance_r));

    j     = (32'(idx_eff) >= NUM_GAINS) ? '0 : idx_eff;
    j_inc = {1'b0, j} + (IDX_W+1)'(1);
    j_adv = (32'(j_inc) >= NUM_GAINS) ? '0 : j_inc[IDX_W-1:0];

    gj = g_eff[j];
    dj = d_eff[j];
    tj = tenth_r[j];
    // round-half-toward-zero tenth, so 0.9x = x - this rounds ties away from zero
    t_dn     = dj[GAIN_W-1] ? (tj.up + GAIN_W'(tj.tie)) : (tj.up - GAIN_W'(tj.tie));
    d_up11   = sat32((GAIN_W+2)'(dj) + (GAIN_W+2)'(tj.up));
    d_dn9    = sat32((GAIN_W+2)'(dj) - (GAIN_W+2)'(t_dn));
    g_plus   = sat32((GAIN_W+2)'(gj) + (GAIN_W+2)'(dj));
    g_minus2 = sat32((GAIN_W+2)'(gj) - ((GAIN_W+2)'(dj) <<< 1));

    gain_nxt  = g_eff;
    delta_nxt = d_eff;
    best_nxt  = best_eff;
    idx_nxt   = idx_eff;
    ph_nxt    = ph_eff;
    fin_nxt   = fin_eff;

    if (run_end) begin
      sum_nxt = '0;
      cnt_nxt = '0;
      if (!fin_eff) begin
        if (delta_total <= tol_ext) begin
          fin_nxt = 1'b1;
        end else begin
          idx_nxt = j;
          unique case (ph_eff)
            PH_TRY_MINUS: begin
              if (better) begin
                best_nxt     = sum_new;
                delta_nxt[j] = d_up11;
                idx_nxt      = j_adv;
                ph_nxt       = PH_TRY_PLUS;
              end else begin
                gain_nxt[j] = g_minus2;
                ph_nxt      = PH_SETTLE;
              end
            end
            PH_SETTLE: begin
              if (better) begin
                best_nxt     = sum_new;
                delta_nxt[j] = d_up11;
              end else begin
                gain_nxt[j]  = g_plus;
                delta_nxt[j] = d_dn9;
              end
              idx_nxt = j_adv;
              ph_nxt  = PH_TRY_PLUS;
            end
            default: begin
              if (better) begin
                best_nxt = sum_new;
              end
              gain_nxt[j] = g_plus;
              ph_nxt      = PH_TRY_MINUS;
            end
          endcase
        end
      end
    end else begin
      sum_nxt = sum_new;
      cnt_nxt = cnt_inc[RUN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      best_r <= ERR_MAX;
      idx_r  <= '0;
      ph_r   <= PH_TRY_PLUS;
      fin_r  <= 1'b0;
      for (int i = 0; i < NUM_GAINS; i++) begin
        gain_r[i]  <= '0;
        delta_r[i] <= '0;
      end
    end else if (fire_ab) begin
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      best_r  <= best_nxt;
      idx_r   <= idx_nxt;
      ph_r    <= ph_nxt;
      fin_r   <= fin_nxt;
      gain_r  <= gain_nxt;
      delta_r <= delta_nxt;
    end
  end

  // tenths are registered from the deltas; a changed delta is not scaled again
  // until at least two run ends later, and restart loads its tenth directly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_GAINS; i++) begin
        tenth_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_GAINS; i++) begin
        tenth_r[i] <= tenth((fire_ab && a_restart_r) ? restart_delta_r : delta_r[i]);
      end
    end
  end

  // ---------------- result register ----------------
  for (genvar k = 0; k < INIT_GAINS; k++) begin : g_res
    if (k < NUM_GAINS) begin : g_used
      assign res_gain[k] = gain_nxt[k];
    end else begin : g_unused
      assign res_gain[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (fire_ab) begin
      o_vld_r <= 1'b1;
    end else if (!out_stall) begin
      o_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_ab) begin
      o_gain_r      <= res_gain;
      o_run_reset_r <= run_end;
      o_done_r      <= fin_nxt;
    end
  end

  // ---------------- assertions ----------------
  a_restart_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_ab && a_restart_r) |=> (sum_r == '0 || sum_r == ERR_W'($past(a_sq_r))))
    else $error("error sum not restarted from the restart word");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    fire_ab |=> (32'(idx_r) < NUM_GAINS))
    else $error("gain index out of range");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_ab && fin_r && !a_restart_r) |=>
      (gain_r[0] == $past(gain_r[0]) && delta_r[0] == $past(delta_r[0])))
    else $error("gains moved after tuning finished");

  a_run_reset: assert property (@(posedge clk) disable iff (!rst_n)
    fire_ab |=> (out_run_reset == (cnt_r == '0)))
    else $error("run_reset disagrees with the sample counter");

endmodule

`default_nettype wire

// ===== test/twiddle_gain_autotuner_unit_checker.sv =====
// checker for the twiddle gain autotuner: predicts each result word and compares it
`timescale 1ns / 100ps

module twiddle_gain_autotuner_unit_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [tga_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tga_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [tga_pkg::SAMPLE_W-1:0]  in_error_sample,
  input  logic                                 in_restart,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [tga_pkg::GAIN_W-1:0]    out_gain_p,
  input  logic signed [tga_pkg::GAIN_W-1:0]    out_gain_i,
  input  logic signed [tga_pkg::GAIN_W-1:0]    out_gain_d,
  input  logic                                 out_run_reset,
  input  logic                                 out_tuning_done,
  output int                                   fail_count,
  output int                                   pending_words,
  output int                                   words_checked,
  output int                                   run_ends,
  output int                                   tune_steps
);
  import tga_pkg::*;

  localparam int NG = NUM_GAINS_DEF;
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic signed [GAIN_W-1:0] p;
    logic signed [GAIN_W-1:0] i;
    logic signed [GAIN_W-1:0] d;
    logic                     run_reset;
    logic                     done;
  } gain_word_t;

  // register copies
  logic [RUN_W-1:0]         run_len_cfg;
  logic [TOL_W-1:0]         tol_cfg;
  logic signed [GAIN_W-1:0] start_gain [NG];

  // tuner state
  int unsigned              sample_cnt;
  logic [ERR_W-1:0]         err_acc;
  logic [ERR_W-1:0]         lowest_score;
  logic signed [GAIN_W-1:0] gain_q [NG];
  logic signed [GAIN_W-1:0] step_q [NG];
  int unsigned              coord;
  phase_t                   phase;
  logic                     frozen;

  gain_word_t gains_due_q [$];
  gain_word_t fresh_word;
  gain_word_t seen_word;
  gain_word_t due_word;

  function automatic logic signed [GAIN_W-1:0] clamp_q824(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return GAIN_W'(v);
  endfunction

  // v * num / 10, nearest with halves away from zero
  function automatic logic signed [GAIN_W-1:0] mul_tenths(input logic signed [GAIN_W-1:0] v,
                                                         input int num);
    longint          prod;
    longint unsigned mag;
    longint          q;
    prod = longint'(v) * num;
    mag  = (prod < 0) ? -prod : prod;
    q    = longint'((mag + 64'd5) / 64'd10);
    return clamp_q824((prod < 0) ? -q : q);
  endfunction

  task automatic reload_gains();
    logic signed [GAIN_W-1:0] top;
    for (int k = 0; k < NG; k++) gain_q[k] = start_gain[k];
    top = gain_q[0];
    for (int k = 1; k < NG; k++) if (gain_q[k] > top) top = gain_q[k];
    for (int k = 0; k < NG; k++) step_q[k] = mul_tenths(top, 1);
    lowest_score = ERR_MAX;
    frozen       = 1'b0;
    coord        = 0;
    phase        = PH_TRY_PLUS;
    err_acc      = '0;
    sample_cnt   = 0;
  endtask

  task automatic next_coord();
    coord = (coord + 1 >= NG) ? 0 : coord + 1;
    phase = PH_TRY_PLUS;
  endtask

  task automatic tune_step(input logic [ERR_W-1:0] err);
    logic better;
    better = err < lowest_score;
    tune_steps++;
    case (phase)
      PH_TRY_PLUS: begin
        if (better) lowest_score = err;
        gain_q[coord] = clamp_q824(longint'(gain_q[coord]) + longint'(step_q[coord]));
        phase = PH_TRY_MINUS;
      end
      PH_TRY_MINUS: begin
        if (better) begin
          lowest_score  = err;
          step_q[coord] = mul_tenths(step_q[coord], 11);
          next_coord();
        end else begin
          gain_q[coord] = clamp_q824(longint'(gain_q[coord]) - 2 * longint'(step_q[coord]));
          phase = PH_SETTLE;
        end
      end
      default: begin
        if (better) begin
          lowest_score  = err;
          step_q[coord] = mul_tenths(step_q[coord], 11);
        end else begin
          gain_q[coord] = clamp_q824(longint'(gain_q[coord]) + longint'(step_q[coord]));
          step_q[coord] = mul_tenths(step_q[coord], 9);
        end
        next_coord();
      end
    endcase
  endtask

  task automatic predict_word(input logic signed [SAMPLE_W-1:0] smp, input logic reload,
                              output gain_word_t w);
    longint         sq;
    longint         total;
    int unsigned    nxt;
    logic [ERR_W:0] widened;
    if (reload) reload_gains();
    sq      = longint'(smp) * longint'(smp);
    widened = {1'b0, err_acc} + (ERR_W+1)'(sq);
    err_acc = widened[ERR_W] ? ERR_MAX : widened[ERR_W-1:0];
    nxt     = sample_cnt + 1;
    w.run_reset = 1'b0;
    if (nxt > run_len_cfg) begin
      w.run_reset = 1'b1;
      run_ends++;
      if (!frozen) begin
        total = 0;
        for (int k = 0; k < NG; k++) total += step_q[k];
        // a negative delta sum also counts as converged
        if (total <= longint'(tol_cfg)) frozen = 1'b1;
        else tune_step(err_acc);
      end
      err_acc    = '0;
      sample_cnt = 0;
    end else begin
      sample_cnt = nxt;
    end
    w.p    = gain_q[0];
    w.i    = gain_q[1];
    w.d    = gain_q[2];
    w.done = frozen;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      run_len_cfg = RUN_LENGTH_RST;
      tol_cfg     = TOLERANCE_RST;
      for (int k = 0; k < NG; k++) begin
        start_gain[k] = '0;
        gain_q[k]     = '0;
        step_q[k]     = '0;
      end
      sample_cnt    = 0;
      err_acc       = '0;
      lowest_score  = ERR_MAX;
      coord         = 0;
      phase         = PH_TRY_PLUS;
      frozen        = 1'b0;
      fail_count    = 0;
      words_checked = 0;
      run_ends      = 0;
      tune_steps    = 0;
      gains_due_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RUN_LENGTH: run_len_cfg   = cfg_wr_data[RUN_W-1:0];
          REG_TOLERANCE:  tol_cfg       = cfg_wr_data[TOL_W-1:0];
          REG_INITIAL_KP: start_gain[0] = cfg_wr_data;
          REG_INITIAL_KI: start_gain[1] = cfg_wr_data;
          REG_INITIAL_KD: start_gain[2] = cfg_wr_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_word(in_error_sample, in_restart, fresh_word);
        gains_due_q.push_back(fresh_word);
      end
      if (out_valid && !out_stall) begin
        seen_word = '{out_gain_p, out_gain_i, out_gain_d, out_run_reset, out_tuning_done};
        if (gains_due_q.size() == 0) begin
          fail_count++;
          if (fail_count <= PRINT_CAP)
            $display("%0t: result word with nothing expected: p=%h i=%h d=%h rr=%b done=%b",
                     $time, seen_word.p, seen_word.i, seen_word.d, seen_word.run_reset,
                     seen_word.done);
        end else begin
          due_word = gains_due_q.pop_front();
          words_checked++;
          if (seen_word !== due_word) begin
            fail_count++;
            if (fail_count <= PRINT_CAP) begin
              $display("%0t: word %0d expected p=%h i=%h d=%h rr=%b done=%b", $time,
                       words_checked, due_word.p, due_word.i, due_word.d,
                       due_word.run_reset, due_word.done);
              $display("%0t: word %0d actual   p=%h i=%h d=%h rr=%b done=%b", $time,
                       words_checked, seen_word.p, seen_word.i, seen_word.d,
                       seen_word.run_reset, seen_word.done);
            end
          end
        end
      end
    end
    pending_words = gains_due_q.size();
  end

endmodule

// ===== test/twiddle_gain_autotuner_unit_tb.sv =====
// testbench top for the twiddle gain autotuner: stimulus, register settings and verdict
`timescale 1ns / 100ps

module twiddle_gain_autotuner_unit_tb;
  import tga_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_SETTINGS = 12;

  typedef enum {
    SRC_ANY,
    SRC_QUIET,
    SRC_FALLING
  } sample_src_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_wr_data;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [SAMPLE_W-1:0]   in_error_sample;
  logic                         in_restart;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [GAIN_W-1:0]     out_gain_p;
  logic signed [GAIN_W-1:0]     out_gain_i;
  logic signed [GAIN_W-1:0]     out_gain_d;
  logic                         out_run_reset;
  logic                         out_tuning_done;

  int fail_count;
  int pending_words;
  int words_checked;
  int run_ends;
  int tune_steps;

  int          cycles = 0;
  int          words_sent = 0;
  int          settings_used = 0;
  int          stall_left = 0;
  int          fall_mag = 32767;
  logic        sender_idle_on = 1'b1;
  logic        recv_calm = 1'b0;
  logic        quiet = 1'b0;
  sample_src_t src;
  int          src_left;
  int          word_count;
  logic [RUN_W-1:0]         rl;
  logic [TOL_W-1:0]         tol;
  logic signed [GAIN_W-1:0] kp;
  logic signed [GAIN_W-1:0] ki;
  logic signed [GAIN_W-1:0] kd;

  twiddle_gain_autotuner_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_error_sample (in_error_sample),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_gain_p      (out_gain_p),
    .out_gain_i      (out_gain_i),
    .out_gain_d      (out_gain_d),
    .out_run_reset   (out_run_reset),
    .out_tuning_done (out_tuning_done)
  );

  twiddle_gain_autotuner_unit_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_error_sample (in_error_sample),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_gain_p      (out_gain_p),
    .out_gain_i      (out_gain_i),
    .out_gain_d      (out_gain_d),
    .out_run_reset   (out_run_reset),
    .out_tuning_done (out_tuning_done),
    .fail_count      (fail_count),
    .pending_words   (pending_words),
    .words_checked   (words_checked),
    .run_ends        (run_ends),
    .tune_steps      (tune_steps)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, pending_words);
      $display("twiddle_gain_autotuner_unit: mismatch");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet || recv_calm) begin
        out_stall  = 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_stall  = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input sample_src_t kind);
    int v;
    case (kind)
      SRC_ANY: return SAMPLE_W'($urandom());
      SRC_QUIET: begin
        v = int'($urandom_range(0, 128)) - 64;
        return SAMPLE_W'(v);
      end
      default: begin
        // shrinking magnitude makes each run score better than the last until it wraps
        if (fall_mag < 100) fall_mag = 32767;
        else fall_mag -= $urandom_range(1, 99);
        v = $urandom_range(0, 1) ? -fall_mag : fall_mag;
        return SAMPLE_W'(v);
      end
    endcase
  endfunction

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return GAIN_W'($urandom());
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      3: return '0;
      default: return GAIN_W'(int'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic reload);
    int gap;
    if (sender_idle_on && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_error_sample = smp;
    in_restart      = reload;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid   = 1'b0;
    in_restart = 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en   = 1'b1;
    cfg_index   = idx;
    cfg_wr_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic apply_setting();
    drain();
    // unused upper data bits carry noise
    write_reg(REG_RUN_LENGTH, {16'($urandom()), rl});
    write_reg(REG_TOLERANCE, {1'($urandom()), tol});
    write_reg(REG_INITIAL_KP, kp);
    write_reg(REG_INITIAL_KI, ki);
    write_reg(REG_INITIAL_KD, kd);
    repeat (3) @(negedge clk);
    settings_used++;
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = '0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_error_sample = '0;
    in_restart      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // no restart yet: all deltas zero, first run end converges at once
    write_reg(REG_RUN_LENGTH, '0);
    repeat (3) @(negedge clk);
    settings_used++;
    send_word(16'sh7FFF, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh0000, 1'b0);

    // directed runs of three words walking every twiddle phase
    rl = 16'd2;
    tol = '0;
    kp = 32'sh0100_0000;
    ki = 32'sh8000_0000;
    kd = 32'sh7FFF_FFFF;
    apply_setting();
    send_word(16'sh0100, 1'b1);
    send_word(16'sh0100, 1'b0);
    send_word(16'sh0100, 1'b0);
    send_word(16'sh7FFF, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7FFF, 1'b0);
    repeat (3) send_word(16'sh8000, 1'b0);
    send_word(16'sh0000, 1'b0);
    send_word(16'sh0000, 1'b0);
    send_word(16'sh0001, 1'b0);
    repeat (6) send_word(16'sh0000, 1'b0);
    send_word(16'sh0001, 1'b1);
    send_word(16'shFFFF, 1'b0);

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      case (ph)
        0: begin
          rl = 16'hFFFF;
          tol = 31'h7FFF_FFFF;
          kp = 32'sh7FFF_FFFF;
          ki = 32'sh8000_0000;
          kd = '0;
          word_count = 40;
        end
        1: begin
          // negative gains give a negative delta sum
          rl = 16'd1;
          tol = '0;
          kp = 32'sh8000_0000;
          ki = -GAIN_W'($urandom_range(1, 32'h7FFF_FFFF));
          kd = -GAIN_W'($urandom_range(1, 32'h0100_0000));
          word_count = 30;
        end
        2: begin
          // steady improvement grows the deltas until they saturate
          rl = '0;
          tol = '0;
          kp = 32'sh1000_0000;
          ki = 32'sh8000_0000;
          kd = 32'sh7FFF_FFFF;
          word_count = 300;
        end
        default: begin
          rl = ($urandom_range(0, 3) == 0) ? RUN_W'($urandom_range(7, 40))
                                           : RUN_W'($urandom_range(1, 6));
          tol = ($urandom_range(0, 3) == 0) ? TOL_W'($urandom())
                                            : TOL_W'($urandom_range(0, 200000));
          kp = pick_gain();
          ki = pick_gain();
          kd = pick_gain();
          word_count = 120;
        end
      endcase
      apply_setting();
      quiet = (ph == NUM_SETTINGS - 1);
      src_left = 0;
      for (int n = 0; n < word_count; n++) begin
        if (src_left == 0) begin
          src_left       = $urandom_range(10, 60);
          src            = (ph == 2) ? SRC_FALLING : sample_src_t'($urandom_range(0, 2));
          sender_idle_on = $urandom_range(0, 3) != 0;
          recv_calm      = $urandom_range(0, 3) == 0;
        end
        src_left--;
        // hold off mid-setting until the block has caught up
        if (ph == 5 && n == word_count / 2) drain();
        send_word(pick_sample(src), n == 0 || $urandom_range(0, 199) == 0);
      end
    end

    in_valid   = 1'b0;
    in_restart = 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("sent %0d sample words under %0d register settings, %0d result words checked",
             words_sent, settings_used, words_checked);
    $display("covered %0d run ends and %0d tuning steps", run_ends, tune_steps);
    if (fail_count == 0 && pending_words == 0) begin
      $display("twiddle_gain_autotuner_unit: match");
    end else begin
      $display("twiddle_gain_autotuner_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== twiddle_gain_autotuner_unit.f =====
rtl/tga_pkg.sv
rtl/twiddle_gain_autotuner_unit.sv
test/twiddle_gain_autotuner_unit_checker.sv
test/twiddle_gain_autotuner_unit_tb.sv
